>>> design/apb_pkg.sv
// Shared types, register indexes and arithmetic helpers for the pixel blend core.
package apb_pkg;

  localparam int unsigned InDataW  = 192;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned NumChan  = 4;
  localparam int unsigned PipeDepth = 4;

  localparam logic [CfgIdxW-1:0] RegBlendMode = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOpacity   = 2'd1;

  typedef enum logic [1:0] {
    MODE_CONST_ALPHA = 2'd0,
    MODE_BILINEAR    = 2'd1,
    MODE_BILINEAR_OPA = 2'd2
  } blend_mode_e;

  // Load enables of the three lane stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } apb_stage_en_t;

  // Byte lerp in a 16-bit lane: a + (((b - a) * w) mod 2^16 >> 8), wrapped to a byte.
  function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                       input logic [8:0] w);
    logic [15:0] diff;
    logic [24:0] prod;
    diff = {8'h00, b} - {8'h00, a};
    prod = diff * w;
    return a + prod[15:8];
  endfunction

endpackage

>>> design/affine_pixel_blend_core.sv
// Pixel blend core: bilinear sampling and blending of texels into a destination pixel.
// The core takes one input word per clock and returns one result word per clock while the
// output is not stalled. Each word passes four register stages (row lerps, column lerp,
// opacity scale, destination blend), and its result is offered from the last of them, the
// output register. Every stage has its own valid bit and fills bubbles, so while a finished
// result waits on the output register the input stays ready until the three stages behind
// it have filled. blend_mode and opacity are sampled live and must only be written while no
// word is in flight.
module affine_pixel_blend_core import apb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // dest_pixel, texel_top_left, texel_top_right, texel_bottom_left,
  // texel_bottom_right, frac_x, frac_y (from bit 0 up)
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // result_pixel
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic [1:0]  mode_q;
  logic [7:0]  opacity_q;

  logic        vld1_q, vld2_q, vld3_q, vld4_q;
  logic        rdy1, rdy2, rdy3, rdy4;
  apb_stage_en_t en;
  logic        en4;

  logic [31:0] dest_in, tl_in, tr_in, bl_in, br_in;
  logic [15:0] frac_x_in, frac_y_in;
  logic [8:0]  fx;
  logic [8:0]  fy_d, fy_q;
  logic [31:0] dest1_q, dest2_q, dest3_q;
  logic [31:0] val3;
  logic [31:0] res_d, res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_CONST_ALPHA;
      opacity_q <= 8'hFF;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegBlendMode) begin
        mode_q <= cfg_wdata_i[1:0];
      end else if (cfg_idx_i == RegOpacity) begin
        opacity_q <= cfg_wdata_i;
      end
    end
  end

  // A stage can load when it is empty or its word moves on in the same cycle.
  assign rdy4 = !vld4_q || m_axis_tready;
  assign rdy3 = !vld3_q || rdy4;
  assign rdy2 = !vld2_q || rdy3;
  assign rdy1 = !vld1_q || rdy2;
  assign s_axis_tready = rdy1;

  assign en.s1 = rdy1 && s_axis_tvalid;
  assign en.s2 = rdy2 && vld1_q;
  assign en.s3 = rdy3 && vld2_q;
  assign en4   = rdy4 && vld3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      if (rdy1) vld1_q <= s_axis_tvalid;
      if (rdy2) vld2_q <= vld1_q;
      if (rdy3) vld3_q <= vld2_q;
      if (rdy4) vld4_q <= vld3_q;
    end
  end

  assign dest_in   = s_axis_tdata[31:0];
  assign tl_in     = s_axis_tdata[63:32];
  assign tr_in     = s_axis_tdata[95:64];
  assign bl_in     = s_axis_tdata[127:96];
  assign br_in     = s_axis_tdata[159:128];
  assign frac_x_in = s_axis_tdata[175:160];
  assign frac_y_in = s_axis_tdata[191:176];

  assign fx   = {1'b0, frac_x_in[15:8]};
  // The vertical weight reaches 256 when the top fraction bit is set and the high byte is full.
  assign fy_d = {1'b0, frac_y_in[15:8]} + {8'h00, frac_y_in[15]};

  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      fy_q    <= fy_d;
      dest1_q <= dest_in;
    end
    if (en.s2) dest2_q <= dest1_q;
    if (en.s3) dest3_q <= dest2_q;
  end

  for (genvar c = 0; c < NumChan; c++) begin : g_lane
    apb_lane u_lane (
      .clk_i     (clk_i),
      .en_i      (en),
      .mode_i    (mode_q),
      .opacity_i (opacity_q),
      .dest_i    (dest_in[8*c +: 8]),
      .tl_i      (tl_in[8*c +: 8]),
      .tr_i      (tr_in[8*c +: 8]),
      .bl_i      (bl_in[8*c +: 8]),
      .br_i      (br_in[8*c +: 8]),
      .fx_i      (fx),
      .fy_i      (fy_q),
      .val_o     (val3[8*c +: 8])
    );
  end

  // Stage 4, bilinear modes only: additive destination blend weighted by the sampled alpha.
  always_comb begin
    logic [7:0]  dc;
    logic [15:0] dprod;
    logic [8:0]  keep;
    logic [8:0]  sum;
    res_d = val3;
    for (int c = 0; c < NumChan; c++) begin
      dc    = dest3_q[8*c +: 8];
      dprod = dc * val3[31:24];
      keep  = {1'b0, dc} - {1'b0, dprod[15:8]};
      sum   = {1'b0, val3[8*c +: 8]} + keep;
      if (mode_q != MODE_CONST_ALPHA) begin
        res_d[8*c +: 8] = sum[8] ? 8'hFF : sum[7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = vld4_q;
  assign m_axis_tdata  = res_q;

endmodule

>>> design/apb_lane.sv
// One 8-bit channel of the blend datapath: horizontal lerp, vertical lerp, opacity scale.
module apb_lane import apb_pkg::*; (
  input  logic          clk_i,
  input  apb_stage_en_t en_i,
  input  logic [1:0]    mode_i,
  input  logic [7:0]    opacity_i,
  input  logic [7:0]    dest_i,
  input  logic [7:0]    tl_i,
  input  logic [7:0]    tr_i,
  input  logic [7:0]    bl_i,
  input  logic [7:0]    br_i,
  input  logic [8:0]    fx_i,
  input  logic [8:0]    fy_i,
  output logic [7:0]    val_o
);

  logic        const_mode;
  logic        scale_mode;
  logic [15:0] diff_s1;
  logic [23:0] kprod_s1;
  logic [15:0] p1_d, p1_q;
  logic [7:0]  dest1_q;
  logic [15:0] sum_s2;
  logic [7:0]  m2_d, m2_q;
  logic [8:0]  opas;
  logic [16:0] sprod_s3;
  logic [7:0]  v3_d, v3_q;

  assign const_mode = (mode_i == MODE_CONST_ALPHA);
  assign scale_mode = (mode_i >= MODE_BILINEAR_OPA);

  // Stage 1: the constant-alpha product, or the top and bottom row lerps packed together.
  always_comb begin
    diff_s1  = {8'h00, tl_i} - {8'h00, dest_i};
    kprod_s1 = diff_s1 * opacity_i;
    if (const_mode) begin
      p1_d = kprod_s1[15:0];
    end else begin
      p1_d = {lerp8(tl_i, tr_i, fx_i), lerp8(bl_i, br_i, fx_i)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      p1_q    <= p1_d;
      dest1_q <= dest_i;
    end
  end

  // Stage 2: finish the constant-alpha blend, or lerp between the two rows.
  always_comb begin
    sum_s2 = {dest1_q, 8'h00} + p1_q;
    if (const_mode) begin
      m2_d = sum_s2[15:8];
    end else begin
      m2_d = lerp8(p1_q[15:8], p1_q[7:0], fy_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      m2_q <= m2_d;
    end
  end

  // Stage 3: optional opacity scale; an opacity of 255 maps to a factor of 256.
  always_comb begin
    opas     = {1'b0, opacity_i} + {8'h00, opacity_i[7]};
    sprod_s3 = m2_q * opas;
    if (scale_mode) begin
      v3_d = sprod_s3[15:8];
    end else begin
      v3_d = m2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      v3_q <= v3_d;
    end
  end

  assign val_o = v3_q;

endmodule

>>> design/apb_checker.sv
// Port-level checks of the pixel blend core, bound to the top level.
module apb_checker import apb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata
);

  logic [2:0] inflight_d, inflight_q;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    inflight_d = inflight_q;
    if (in_acc && !out_acc) inflight_d = inflight_q + 3'd1;
    else if (out_acc && !in_acc) inflight_d = inflight_q - 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) inflight_q <= 3'd0;
    else         inflight_q <= inflight_d;
  end

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output word changed");

  // With the output register empty every stage can move.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input not ready while output is empty");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'(PipeDepth))
    else $error("more words in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> inflight_q != 3'd0)
    else $error("output word without an accepted input");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q == 3'(PipeDepth) && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while pipeline is full and stalled");

endmodule

bind affine_pixel_blend_core apb_checker u_apb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> test/affine_pixel_blend_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the pixel blend core: a directed table, then random streams.
module affine_pixel_blend_core_tb;
  import apb_pkg::*;

  // Indexes with no register behind them; writes there must change nothing.
  localparam logic [CfgIdxW-1:0] RegSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareB = 2'd3;
  localparam logic [1:0] ModeThree = 2'd3;
  localparam int SettleCycles = 2 * PipeDepth;
  localparam int IdleLimit = 2000;
  localparam int LongHold = 150;

  // Packed from frac_y down to dest_pixel, so dest_pixel lands in the lowest tdata bits.
  typedef struct packed {
    logic [15:0] frac_y;
    logic [15:0] frac_x;
    logic [31:0] texel_bottom_right;
    logic [31:0] texel_bottom_left;
    logic [31:0] texel_top_right;
    logic [31:0] texel_top_left;
    logic [31:0] dest_pixel;
  } pixel_req_t;

  typedef enum logic {
    ROW_REG,
    ROW_PIXEL
  } row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CfgIdxW-1:0]    reg_idx;
    logic [CfgDataW-1:0]   reg_val;
    pixel_req_t            req;
    bit                    known;
    logic [OutDataW-1:0]   result;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  logic [1:0]          blend_mode_q;
  logic [7:0]          opacity_q;
  logic [OutDataW-1:0] expected_pixels[$];
  stim_row_t           directed_rows[$];
  int                  mismatches = 0;
  int                  idle_cycles = 0;
  int                  hold_cycles = 0;
  bit                  quiet = 1'b0;

  affine_pixel_blend_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [7:0] row_lerp(input logic [7:0] a, input logic [7:0] b,
                                          input logic [8:0] w);
    logic [15:0] diff;
    logic [15:0] prod;
    diff = {8'h00, b} - {8'h00, a};
    prod = diff * w;
    return a + prod[15:8];
  endfunction

  function automatic logic [OutDataW-1:0] blend_pixel(input pixel_req_t p,
                                                      input logic [1:0] mode,
                                                      input logic [7:0] opa);
    logic [7:0]          d;
    logic [7:0]          s;
    logic [7:0]          top;
    logic [7:0]          bot;
    logic [7:0]          alpha;
    logic [7:0]          mix[NumChan];
    logic [15:0]         k;
    logic [15:0]         acc;
    logic [8:0]          wx;
    logic [8:0]          wy;
    logic [8:0]          opa_s;
    logic [OutDataW-1:0] res;
    res = '0;
    if (mode == MODE_CONST_ALPHA) begin
      for (int c = 0; c < NumChan; c++) begin
        d = p.dest_pixel[8*c +: 8];
        s = p.texel_top_left[8*c +: 8];
        k = ({8'h00, s} - {8'h00, d}) * opa;
        acc = {d, 8'h00} + k;
        res[8*c +: 8] = acc[15:8];
      end
    end else begin
      wx = {1'b0, p.frac_x[15:8]};
      // A frac_y of 0xFF00 or more reaches a full weight of 256.
      wy = {1'b0, p.frac_y[15:8]} + {8'h00, p.frac_y[15]};
      opa_s = {1'b0, opa} + {8'h00, opa[7]};
      for (int c = 0; c < NumChan; c++) begin
        top = row_lerp(p.texel_top_left[8*c +: 8], p.texel_top_right[8*c +: 8], wx);
        bot = row_lerp(p.texel_bottom_left[8*c +: 8], p.texel_bottom_right[8*c +: 8], wx);
        mix[c] = row_lerp(top, bot, wy);
        if (mode >= MODE_BILINEAR_OPA) begin
          acc = mix[c] * opa_s;
          mix[c] = acc[15:8];
        end
      end
      alpha = mix[NumChan-1];
      for (int c = 0; c < NumChan; c++) begin
        d = p.dest_pixel[8*c +: 8];
        acc = d * alpha;
        acc = {8'h00, d} - {8'h00, acc[15:8]} + {8'h00, mix[c]};
        res[8*c +: 8] = (acc > 16'd255) ? 8'hFF : acc[7:0];
      end
    end
    return res;
  endfunction

  function automatic pixel_req_t make_req(input logic [31:0] d, input logic [31:0] tl,
                                          input logic [31:0] tr, input logic [31:0] bl,
                                          input logic [31:0] br, input logic [15:0] fx,
                                          input logic [15:0] fy);
    pixel_req_t p;
    p.dest_pixel = d;
    p.texel_top_left = tl;
    p.texel_top_right = tr;
    p.texel_bottom_left = bl;
    p.texel_bottom_right = br;
    p.frac_x = fx;
    p.frac_y = fy;
    return p;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return $urandom | 32'hFF00_0000;
      3: return $urandom & 32'h00FF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_frac();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFF00 | 16'($urandom_range(0, 255));
      2: return 16'h8000 | 16'($urandom_range(0, 255));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic pixel_req_t random_pixel();
    pixel_req_t  p;
    logic [31:0] base;
    p.dest_pixel = pick_word();
    if ($urandom_range(0, 3) == 0) begin
      // Nearly flat neighborhoods keep the lerps close to their end points.
      base = pick_word();
      p.texel_top_left = base;
      p.texel_top_right = base ^ ($urandom & 32'h0F0F_0F0F);
      p.texel_bottom_left = base;
      p.texel_bottom_right = base ^ ($urandom & 32'h0F0F_0F0F);
    end else begin
      p.texel_top_left = pick_word();
      p.texel_top_right = pick_word();
      p.texel_bottom_left = pick_word();
      p.texel_bottom_right = pick_word();
    end
    p.frac_x = pick_frac();
    p.frac_y = pick_frac();
    return p;
  endfunction

  task automatic report_mismatch(input string what, input logic [OutDataW-1:0] got,
                                 input logic [OutDataW-1:0] want);
    $display("mismatch %s: got %08h expected %08h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic add_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    stim_row_t row;
    row.kind = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    row.req = '0;
    row.known = 1'b0;
    row.result = '0;
    directed_rows.push_back(row);
  endtask

  task automatic add_pixel(input pixel_req_t req, input bit known,
                           input logic [OutDataW-1:0] result);
    stim_row_t row;
    row.kind = ROW_PIXEL;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.req = req;
    row.known = known;
    row.result = result;
    directed_rows.push_back(row);
  endtask

  task automatic wait_drained();
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    s_axis_tvalid = 1'b0;
    wait_drained();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == RegBlendMode) begin
      blend_mode_q = val[1:0];
    end else if (idx == RegOpacity) begin
      opacity_q = val;
    end
  endtask

  // Offers one word and returns at the falling edge after it has been taken.
  task automatic send_pixel(input pixel_req_t req, input bit known,
                            input logic [OutDataW-1:0] result);
    s_axis_tdata = req;
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_pixels.push_back(known ? result : blend_pixel(req, blend_mode_q, opacity_q));
    @(negedge clk_i);
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
  endtask

  task automatic run_phase(input logic [1:0] mode, input logic [7:0] opa, input int count,
                           input bit long_hold);
    write_reg(RegBlendMode, CfgDataW'(mode));
    write_reg(RegOpacity, opa);
    // The receiver stalls for a long stretch while words keep coming back to back.
    if (long_hold) hold_cycles = LongHold;
    for (int i = 0; i < count; i++) begin
      send_pixel(random_pixel(), 1'b0, '0);
      if (!long_hold) sender_gap();
    end
    s_axis_tvalid = 1'b0;
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      if (hold_cycles > 0) begin
        m_axis_tready = 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        m_axis_tready = 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    logic [OutDataW-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result_pixel with nothing pending", m_axis_tdata, '0);
      end else begin
        want = expected_pixels.pop_front();
        if (m_axis_tdata !== want) report_mismatch("result_pixel", m_axis_tdata, want);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    blend_mode_q = MODE_CONST_ALPHA;
    opacity_q = 8'hFF;

    // Reset values: constant alpha at full opacity, only the top-left texel counts.
    add_pixel(make_req(32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 32'h9ABC_DEF0,
                       32'h0F0F_0F0F, 16'hFFFF, 16'hFFFF), 1'b1, 32'hFEFE_FEFE);
    add_pixel(make_req(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 16'h0000, 16'h0000), 1'b1, 32'h0000_0000);
    add_pixel(make_req(32'h80FF_0010, 32'h7F00_FF20, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0),
              1'b0, '0);
    add_pixel(random_pixel(), 1'b0, '0);
    add_reg(RegOpacity, 8'h00);
    add_pixel(make_req(32'h1234_5678, $urandom, $urandom, $urandom, $urandom, 16'h8000,
                       16'h8000), 1'b1, 32'h1234_5678);
    add_reg(RegSpareA, 8'h55);
    add_reg(RegSpareB, 8'hAA);
    add_pixel(make_req(32'hCAFE_F00D, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0),
              1'b1, 32'hCAFE_F00D);
    add_reg(RegOpacity, 8'h80);
    add_pixel(random_pixel(), 1'b0, '0);
    // Only the low two bits of the mode write are kept, which selects bilinear.
    add_reg(RegBlendMode, 8'hFD);
    add_pixel(make_req(32'hA5A5_5A5A, 32'h0, 32'h0, 32'h0, 32'h0, 16'hFFFF, 16'hFFFF),
              1'b1, 32'hA5A5_5A5A);
    add_pixel(make_req(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 16'h1234, 16'h8765), 1'b1, 32'hFFFF_FFFF);
    add_pixel(make_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 16'hFFFF, 16'h0000), 1'b1, 32'hFFFF_FFFF);
    // Full vertical weight returns the bottom row unchanged.
    add_pixel(make_req(32'h0000_0000, 32'h1111_1111, 32'hEEEE_EEEE, 32'h8040_2010,
                       32'h7F7F_7F7F, 16'h0000, 16'hFFFF), 1'b1, 32'h8040_2010);
    add_pixel(make_req(32'h0000_0000, 32'h1111_1111, 32'hEEEE_EEEE, 32'h8040_2010,
                       32'h7F7F_7F7F, 16'h00FF, 16'hFF80), 1'b1, 32'h8040_2010);
    add_pixel(make_req(32'h5A5A_5A5A, 32'h00FF_00FF, 32'hFF00_FF00, 32'h0F0F_0F0F,
                       32'hF0F0_F0F0, 16'h8000, 16'h8000), 1'b0, '0);
    add_pixel(make_req(32'hC0C0_C0C0, 32'h00FF_00FF, 32'hFF00_FF00, 32'h0F0F_0F0F,
                       32'hF0F0_F0F0, 16'hFFFF, 16'h7FFF), 1'b0, '0);
    add_reg(RegOpacity, 8'hFF);
    add_reg(RegBlendMode, CfgDataW'(MODE_BILINEAR_OPA));
    add_pixel(make_req(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 16'h4321, 16'hBEEF), 1'b1, 32'hFFFF_FFFF);
    add_pixel(random_pixel(), 1'b0, '0);
    add_reg(RegOpacity, 8'h00);
    add_pixel(make_req(32'h0F1E_2D3C, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF), 1'b1, 32'h0F1E_2D3C);
    add_reg(RegOpacity, 8'h7F);
    add_reg(RegBlendMode, CfgDataW'(ModeThree));
    add_pixel(random_pixel(), 1'b0, '0);
    add_pixel(random_pixel(), 1'b0, '0);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_pixel(directed_rows[i].req, directed_rows[i].known, directed_rows[i].result);
        sender_gap();
      end
    end
    s_axis_tvalid = 1'b0;

    run_phase(MODE_BILINEAR, 8'h80, 48, 1'b0);
    run_phase(MODE_BILINEAR_OPA, 8'hFF, 48, 1'b0);
    run_phase(MODE_CONST_ALPHA, 8'h00, 40, 1'b0);
    run_phase(MODE_BILINEAR, 8'hFF, 48, 1'b1);
    run_phase(MODE_BILINEAR_OPA, 8'h00, 40, 1'b0);
    run_phase(ModeThree, 8'($urandom_range(0, 255)), 48, 1'b0);
    run_phase(MODE_CONST_ALPHA, 8'($urandom_range(0, 255)), 48, 1'b0);
    run_phase(MODE_BILINEAR_OPA, 8'h80, 48, 1'b0);
    quiet = 1'b1;
    run_phase(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 64, 1'b0);

    wait_drained();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
design/apb_pkg.sv
design/apb_lane.sv
design/affine_pixel_blend_core.sv
design/apb_checker.sv
test/affine_pixel_blend_core_tb.sv
